### rtl/core/tube_sample_scaler_limit_check_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the tube sample scaler
// Concurrent property wrappers for the RTL that checks itself.
// ----------------------------------------------------------------------------
`ifndef TUBE_SAMPLE_SCALER_LIMIT_CHECK_ASSERT_SVH
`define TUBE_SAMPLE_SCALER_LIMIT_CHECK_ASSERT_SVH

// same-cycle implication, disabled in reset
`define TSSL_ASSERT_IMPLIES(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("tssl: property failed");

// next-cycle implication, disabled in reset
`define TSSL_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("tssl: property failed");

`endif

### rtl/core/tssl_pkg.sv
// ----------------------------------------------------------------------------
// tssl_pkg
// Types, constants and scaling tables for the tube sample scaler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tssl_pkg;

    localparam int CODE_W      = 10;
    localparam int GRID_CODE_W = 12;
    localparam int VREF_W      = 13;
    localparam int LIM_W       = 20;
    localparam int S_DATA_W    = 96;
    localparam int M_DATA_W    = 176;
    localparam int M_PAD_W     = M_DATA_W - 169;

    localparam int PROD_W   = 25;   // code * vref
    localparam int MUL_W    = 23;   // reciprocal
    localparam int SHIFT    = 25;
    localparam int NUM_W    = 33;   // code * vref * numerator
    localparam int DIV_W    = 16;
    localparam int KCONST_W = 9;
    localparam int Q_W      = 23;
    localparam int VAL_W    = 20;
    localparam int POW_W    = 40;
    localparam int OP_W     = 3;
    localparam int CFG_IDX_W = 2;

    localparam logic [OP_W-1:0] OP_HEATER_MV = 3'd0;
    localparam logic [OP_W-1:0] OP_HEATER_MA = 3'd1;
    localparam logic [OP_W-1:0] OP_GRID_MV   = 3'd2;
    localparam logic [OP_W-1:0] OP_ANODE_MV  = 3'd3;
    localparam logic [OP_W-1:0] OP_ANODE_UA  = 3'd4;
    localparam logic [OP_W-1:0] OP_SCREEN_MV = 3'd5;
    localparam logic [OP_W-1:0] OP_SCREEN_UA = 3'd6;

    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_CLEAR  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_VREF_MASTER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VREF_HEATER = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ANODE_LIM   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_POWER_LIM   = 2'd3;

    localparam logic [VREF_W-1:0] VREF_RESET      = 13'd2048;
    localparam logic [LIM_W-1:0]  ANODE_LIM_RESET = 20'd100000;
    localparam logic [LIM_W-1:0]  POWER_LIM_RESET = 20'd25000;

    localparam logic [PROD_W-1:0] RANGE_KNEE  = 25'd3887400;
    localparam logic [LIM_W-1:0]  POWER_SCALE = 20'd1000000;

    typedef struct packed {
        logic [VREF_W-1:0] vref_master_mv;
        logic [VREF_W-1:0] vref_heater_mv;
        logic [LIM_W-1:0]  anode_current_limit_ua;
        logic [LIM_W-1:0]  power_limit_mw;
    } cfg_t;

    typedef struct packed {
        logic                   kind;
        logic [CODE_W-1:0]      heater_v_code;
        logic [CODE_W-1:0]      heater_i_code;
        logic [GRID_CODE_W-1:0] grid_v_code;
        logic [CODE_W-1:0]      anode_v_code;
        logic [CODE_W-1:0]      anode_i_hi_code;
        logic [CODE_W-1:0]      anode_i_lo_code;
        logic [CODE_W-1:0]      screen_v_code;
        logic [CODE_W-1:0]      screen_i_hi_code;
        logic [CODE_W-1:0]      screen_i_lo_code;
    } item_t;

    typedef struct packed {
        logic                   valid;
        logic [OP_W-1:0]        op;
        logic [GRID_CODE_W-1:0] code_a;
        logic [CODE_W-1:0]      code_b;
        logic [VREF_W-1:0]      vref;
    } issue_t;

    typedef struct packed {
        logic             valid;
        logic [OP_W-1:0]  op;
        logic [VAL_W-1:0] value;
    } res_t;

    typedef struct packed {
        logic [KCONST_W-1:0] k;
        logic [DIV_W-1:0]    d;
        logic [MUL_W-1:0]    m;
    } div_const_t;

    typedef struct packed {
        logic [15:0]      heater_mv;
        logic [14:0]      heater_ma;
        logic [17:0]      grid_mv;
        logic [VAL_W-1:0] anode_mv;
        logic [VAL_W-1:0] anode_ua;
        logic [VAL_W-1:0] screen_mv;
        logic [VAL_W-1:0] screen_ua;
        logic [VAL_W-1:0] anode_peak_ua;
        logic [VAL_W-1:0] screen_peak_ua;
        logic             over_limit;
    } out_t;

    // q = p*k/d, taken as (p*m) >> SHIFT and corrected by at most one
    function automatic div_const_t div_const(input logic [OP_W-1:0] op, input logic coarse);
        div_const_t c;
        begin
            case (op)
                OP_HEATER_MV: c = '{k: 9'd377, d: 16'd48081, m: 23'd263098};
                OP_HEATER_MA: c = '{k: 9'd50,  d: 16'd11253, m: 23'd149091};
                OP_GRID_MV:   c = '{k: 9'd11,  d: 16'd2730,  m: 23'd135201};
                OP_ANODE_MV,
                OP_SCREEN_MV: c = '{k: 9'd151, d: 16'd1023,  m: 23'd4952804};
                OP_ANODE_UA,
                OP_SCREEN_UA: begin
                    if (coarse) begin
                        c = '{k: 9'd50, d: 16'd341, m: 23'd4920004};
                    end else begin
                        c = '{k: 9'd5,  d: 16'd341, m: 23'd492000};
                    end
                end
                default:      c = '{k: 9'd0,   d: 16'd1,     m: 23'd0};
            endcase
            return c;
        end
    endfunction

    function automatic logic [VAL_W-1:0] sat_max(input logic [OP_W-1:0] op);
        logic [VAL_W-1:0] mx;
        begin
            case (op)
                OP_HEATER_MV: mx = 20'd65535;
                OP_HEATER_MA: mx = 20'd32767;
                OP_GRID_MV:   mx = 20'd131072;
                default:      mx = 20'hFFFFF;
            endcase
            return mx;
        end
    endfunction

endpackage

### rtl/core/tssl_front.sv
// ----------------------------------------------------------------------------
// tssl_front
// Accepts input words, unpacks and classifies them as sample or clear.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tssl_front (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [tssl_pkg::S_DATA_W-1:0]  s_tdata,
    input  logic                           s_tuser,
    output logic                           out_valid,
    input  logic                           out_ready,
    output tssl_pkg::item_t                out_item
);
    import tssl_pkg::*;

    logic  valid_reg, valid_next;
    item_t item_reg, item_next;
    logic  take;

    assign s_tready  = !valid_reg || out_ready;
    assign take      = s_tvalid && s_tready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    always_comb begin
        item_next = item_reg;
        if (take) begin
            if (s_tuser) begin
                item_next      = '0;
                item_next.kind = KIND_CLEAR;
            end else begin
                item_next.kind             = KIND_SAMPLE;
                item_next.heater_v_code    = s_tdata[9:0];
                item_next.heater_i_code    = s_tdata[19:10];
                item_next.grid_v_code      = s_tdata[31:20];
                item_next.anode_v_code     = s_tdata[41:32];
                item_next.anode_i_hi_code  = s_tdata[51:42];
                item_next.anode_i_lo_code  = s_tdata[61:52];
                item_next.screen_v_code    = s_tdata[71:62];
                item_next.screen_i_hi_code = s_tdata[81:72];
                item_next.screen_i_lo_code = s_tdata[91:82];
            end
        end
        if (take) begin
            valid_next = 1'b1;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg <= item_next;
    end

endmodule

### rtl/core/tssl_queue.sv
// ----------------------------------------------------------------------------
// tssl_queue
// Two-entry queue between front and back; each side stalls on its own.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tssl_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  tssl_pkg::item_t in_item,
    output logic            out_valid,
    input  logic            out_ready,
    output tssl_pkg::item_t out_item
);
    import tssl_pkg::*;

    item_t      slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push, pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_item  = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

### rtl/core/tssl_scale.sv
// ----------------------------------------------------------------------------
// tssl_scale
// Four-stage scaling pipeline: code times reference, reciprocal multiply,
// remainder check and saturation. Takes one quantity per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tssl_scale (
    input  logic             aclk,
    input  logic             aresetn,
    input  tssl_pkg::issue_t issue,
    output tssl_pkg::res_t   res
);
    import tssl_pkg::*;

    // stage A
    logic              a_valid_reg;
    logic [OP_W-1:0]   a_op_reg;
    logic [PROD_W-1:0] a_pa_reg, a_pa_next;
    logic [PROD_W-1:0] a_pb_reg, a_pb_next;
    // stage B
    logic              b_valid_reg;
    logic [OP_W-1:0]   b_op_reg;
    logic [Q_W-1:0]    b_q0_reg, b_q0_next;
    logic [NUM_W-1:0]  b_u_reg, b_u_next;
    logic [DIV_W-1:0]  b_d_reg;
    // stage C
    logic              c_valid_reg;
    logic [OP_W-1:0]   c_op_reg;
    logic [Q_W-1:0]    c_q0_reg;
    logic [NUM_W-1:0]  c_u_reg;
    logic [NUM_W-1:0]  c_v_reg, c_v_next;
    logic [DIV_W-1:0]  c_d_reg;
    // stage D
    logic              d_valid_reg;
    logic [OP_W-1:0]   d_op_reg;
    logic [VAL_W-1:0]  d_val_reg, d_val_next;

    logic                    coarse;
    div_const_t              kc;
    logic [PROD_W-1:0]       p_sel;
    logic [PROD_W+MUL_W-1:0] b_prod;
    logic [NUM_W-1:0]        rem;
    logic [Q_W-1:0]          q;
    logic [VAL_W-1:0]        mx;

    always_comb begin
        a_pa_next = PROD_W'(issue.code_a) * PROD_W'(issue.vref);
        a_pb_next = PROD_W'(issue.code_b) * PROD_W'(issue.vref);

        coarse = ((a_op_reg == OP_ANODE_UA) || (a_op_reg == OP_SCREEN_UA)) &&
                 (a_pa_reg >= RANGE_KNEE);
        kc     = div_const(a_op_reg, coarse);
        p_sel  = coarse ? a_pb_reg : a_pa_reg;
        b_prod = (PROD_W+MUL_W)'(p_sel) * (PROD_W+MUL_W)'(kc.m);
        b_q0_next = b_prod[PROD_W+MUL_W-1:SHIFT];
        b_u_next  = NUM_W'(p_sel) * NUM_W'(kc.k);

        c_v_next = NUM_W'(b_q0_reg) * NUM_W'(b_d_reg);

        rem = c_u_reg - c_v_reg;
        q   = c_q0_reg + Q_W'(rem >= NUM_W'(c_d_reg));
        mx  = sat_max(c_op_reg);
        d_val_next = (q > Q_W'(mx)) ? mx : q[VAL_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end else begin
            a_valid_reg <= issue.valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        a_op_reg <= issue.op;
        a_pa_reg <= a_pa_next;
        a_pb_reg <= a_pb_next;
        b_op_reg <= a_op_reg;
        b_q0_reg <= b_q0_next;
        b_u_reg  <= b_u_next;
        b_d_reg  <= kc.d;
        c_op_reg <= b_op_reg;
        c_q0_reg <= b_q0_reg;
        c_u_reg  <= b_u_reg;
        c_v_reg  <= c_v_next;
        c_d_reg  <= b_d_reg;
        d_op_reg <= c_op_reg;
        d_val_reg <= d_val_next;
    end

    assign res.valid = d_valid_reg;
    assign res.op    = d_op_reg;
    assign res.value = d_val_reg;

endmodule

### rtl/core/tssl_back.sv
// ----------------------------------------------------------------------------
// tssl_back
// Takes queued words, sequences the seven quantities through the scaling
// pipeline, checks the limits, keeps or clears the peaks and holds the result word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tssl_back (
    input  logic             aclk,
    input  logic             aresetn,
    input  tssl_pkg::cfg_t   cfg,
    input  logic             q_valid,
    output logic             q_pop,
    input  tssl_pkg::item_t  q_item,
    output tssl_pkg::issue_t issue,
    input  tssl_pkg::res_t   res,
    output logic             out_valid,
    input  logic             out_ready,
    output tssl_pkg::out_t   out_word
);
    import tssl_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_ISSUE = 3'd1;
    localparam logic [2:0] ST_WAIT  = 3'd2;
    localparam logic [2:0] ST_POWER = 3'd3;
    localparam logic [2:0] ST_CHECK = 3'd4;

    logic [2:0]       state_reg, state_next;
    logic [OP_W-1:0]  cnt_reg, cnt_next;
    item_t            item_reg, item_next;

    logic [15:0]      heater_mv_reg;
    logic [14:0]      heater_ma_reg;
    logic [17:0]      grid_reg;
    logic [VAL_W-1:0] anode_mv_reg, anode_ua_reg, screen_mv_reg, screen_ua_reg;
    logic [POW_W-1:0] pow_reg, pow_next;
    logic [POW_W-1:0] plim_reg, plim_next;
    logic [VAL_W-1:0] anode_peak_reg, screen_peak_reg;
    logic [VAL_W-1:0] anode_peak_new, screen_peak_new;
    logic             out_valid_reg, out_valid_next;
    out_t             out_reg;

    logic out_free, load_clear, load_sample, over;

    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_word  = out_reg;

    // operand select for the quantity being issued
    always_comb begin
        issue.valid  = (state_reg == ST_ISSUE);
        issue.op     = cnt_reg;
        issue.code_a = '0;
        issue.code_b = '0;
        issue.vref   = cfg.vref_master_mv;
        case (cnt_reg)
            OP_HEATER_MV: begin
                issue.code_a = GRID_CODE_W'(item_reg.heater_v_code);
                issue.vref   = cfg.vref_heater_mv;
            end
            OP_HEATER_MA: begin
                issue.code_a = GRID_CODE_W'(item_reg.heater_i_code);
                issue.vref   = cfg.vref_heater_mv;
            end
            OP_GRID_MV:   issue.code_a = item_reg.grid_v_code;
            OP_ANODE_MV:  issue.code_a = GRID_CODE_W'(item_reg.anode_v_code);
            OP_ANODE_UA: begin
                issue.code_a = GRID_CODE_W'(item_reg.anode_i_hi_code);
                issue.code_b = item_reg.anode_i_lo_code;
            end
            OP_SCREEN_MV: issue.code_a = GRID_CODE_W'(item_reg.screen_v_code);
            OP_SCREEN_UA: begin
                issue.code_a = GRID_CODE_W'(item_reg.screen_i_hi_code);
                issue.code_b = item_reg.screen_i_lo_code;
            end
            default: ;
        endcase
    end

    always_comb begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        item_next   = item_reg;
        pow_next    = pow_reg;
        plim_next   = plim_reg;
        q_pop       = 1'b0;
        load_clear  = 1'b0;
        load_sample = 1'b0;

        anode_peak_new  = (anode_ua_reg > anode_peak_reg) ? anode_ua_reg : anode_peak_reg;
        screen_peak_new = (screen_ua_reg > screen_peak_reg) ? screen_ua_reg : screen_peak_reg;
        over = (anode_ua_reg > cfg.anode_current_limit_ua) || (pow_reg > plim_reg);

        case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    if (q_item.kind == KIND_CLEAR) begin
                        if (out_free) begin
                            q_pop      = 1'b1;
                            load_clear = 1'b1;
                        end
                    end else begin
                        q_pop      = 1'b1;
                        item_next  = q_item;
                        cnt_next   = OP_HEATER_MV;
                        state_next = ST_ISSUE;
                    end
                end
            end
            ST_ISSUE: begin
                cnt_next = cnt_reg + OP_W'(1);
                if (cnt_reg == OP_SCREEN_UA) begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT: begin
                if (res.valid && (res.op == OP_SCREEN_UA)) begin
                    state_next = ST_POWER;
                end
            end
            ST_POWER: begin
                pow_next   = POW_W'(anode_ua_reg) * POW_W'(anode_mv_reg);
                plim_next  = POW_W'(cfg.power_limit_mw) * POW_W'(POWER_SCALE);
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                if (out_free) begin
                    load_sample = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        if (load_clear || load_sample) begin
            out_valid_next = 1'b1;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            cnt_reg         <= OP_HEATER_MV;
            out_valid_reg   <= 1'b0;
            anode_peak_reg  <= '0;
            screen_peak_reg <= '0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            if (load_clear) begin
                anode_peak_reg  <= '0;
                screen_peak_reg <= '0;
            end else if (load_sample) begin
                anode_peak_reg  <= anode_peak_new;
                screen_peak_reg <= screen_peak_new;
            end
        end
    end

    // capture pipeline results by quantity
    always_ff @(posedge aclk) begin
        item_reg <= item_next;
        pow_reg  <= pow_next;
        plim_reg <= plim_next;
        if (res.valid) begin
            case (res.op)
                OP_HEATER_MV: heater_mv_reg <= res.value[15:0];
                OP_HEATER_MA: heater_ma_reg <= res.value[14:0];
                OP_GRID_MV:   grid_reg      <= res.value[17:0];
                OP_ANODE_MV:  anode_mv_reg  <= res.value;
                OP_ANODE_UA:  anode_ua_reg  <= res.value;
                OP_SCREEN_MV: screen_mv_reg <= res.value;
                OP_SCREEN_UA: screen_ua_reg <= res.value;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (load_clear) begin
            out_reg <= '0;
        end else if (load_sample) begin
            out_reg.heater_mv      <= heater_mv_reg;
            out_reg.heater_ma      <= heater_ma_reg;
            out_reg.grid_mv        <= 18'd0 - grid_reg;
            out_reg.anode_mv       <= anode_mv_reg;
            out_reg.anode_ua       <= anode_ua_reg;
            out_reg.screen_mv      <= screen_mv_reg;
            out_reg.screen_ua      <= screen_ua_reg;
            out_reg.anode_peak_ua  <= anode_peak_new;
            out_reg.screen_peak_ua <= screen_peak_new;
            out_reg.over_limit     <= over;
        end
    end

endmodule

### rtl/core/tube_sample_scaler_limit_check.sv
// The back end takes a new sample word only once it is through with the last, issuing seven
// quantities one a cycle into a single 4-stage scaling pipeline, then doing the power check.
// Front and back are parted by a 2-entry queue and an output register.
// Reset: synchronous, active-low aresetn; peaks clear to zero and configuration
// returns to 2048 mV references, 100000 uA and 25000 mW limits.
// ----------------------------------------------------------------------------
// tube_sample_scaler_limit_check
// Scales a set of valve tracer converter codes to engineering units, keeps
// current peaks and flags anode over-current or over-dissipation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "tube_sample_scaler_limit_check_assert.svh"

module tube_sample_scaler_limit_check (
    input  logic                               aclk,
    input  logic                               aresetn,
    // heater_v_code, heater_i_code, grid_v_code, anode_v_code, anode_i_hi_code,
    // anode_i_lo_code, screen_v_code, screen_i_hi_code, screen_i_lo_code, zero pad
    input  logic [tssl_pkg::S_DATA_W-1:0]      s_tdata,
    input  logic                               s_tuser,   // req_type
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // heater_mv, heater_ma, grid_mv, anode_mv, anode_ua, screen_mv, screen_ua,
    // anode_peak_ua, screen_peak_ua, zero pad
    output logic [tssl_pkg::M_DATA_W-1:0]      m_tdata,
    output logic                               m_tuser,   // over_limit
    output logic                               m_tvalid,
    input  logic                               m_tready,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [tssl_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tssl_pkg::LIM_W-1:0]         cfg_data
);
    import tssl_pkg::*;

    cfg_t   cfg_reg;
    item_t  front_item, queue_item;
    logic   front_valid, front_ready;
    logic   queue_valid, queue_pop;
    issue_t issue;
    res_t   res;
    out_t   out_word;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.vref_master_mv         <= VREF_RESET;
            cfg_reg.vref_heater_mv         <= VREF_RESET;
            cfg_reg.anode_current_limit_ua <= ANODE_LIM_RESET;
            cfg_reg.power_limit_mw         <= POWER_LIM_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_VREF_MASTER: cfg_reg.vref_master_mv         <= cfg_data[VREF_W-1:0];
                CFG_VREF_HEATER: cfg_reg.vref_heater_mv         <= cfg_data[VREF_W-1:0];
                CFG_ANODE_LIM:   cfg_reg.anode_current_limit_ua <= cfg_data;
                CFG_POWER_LIM:   cfg_reg.power_limit_mw         <= cfg_data;
                default: ;
            endcase
        end
    end

    tssl_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .out_valid (front_valid),
        .out_ready (front_ready),
        .out_item  (front_item)
    );

    tssl_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_item   (front_item),
        .out_valid (queue_valid),
        .out_ready (queue_pop),
        .out_item  (queue_item)
    );

    tssl_scale u_scale (
        .aclk    (aclk),
        .aresetn (aresetn),
        .issue   (issue),
        .res     (res)
    );

    tssl_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .q_valid   (queue_valid),
        .q_pop     (queue_pop),
        .q_item    (queue_item),
        .issue     (issue),
        .res       (res),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_word  (out_word)
    );

    assign m_tdata = {{M_PAD_W{1'b0}},
                      out_word.screen_peak_ua, out_word.anode_peak_ua,
                      out_word.screen_ua, out_word.screen_mv,
                      out_word.anode_ua, out_word.anode_mv,
                      out_word.grid_mv, out_word.heater_ma, out_word.heater_mv};
    assign m_tuser = out_word.over_limit;

    `TSSL_ASSERT_IMPLIES(a_anode_peak_covers, aclk, aresetn, m_tvalid, out_word.anode_peak_ua >= out_word.anode_ua)
    `TSSL_ASSERT_IMPLIES(a_screen_peak_covers, aclk, aresetn, m_tvalid, out_word.screen_peak_ua >= out_word.screen_ua)
    `TSSL_ASSERT_IMPLIES(a_over_needs_current, aclk, aresetn, m_tvalid && m_tuser, out_word.anode_ua != '0)

endmodule
